/* rtl/co2fc_pkg.sv */
// ----------------------------------------------------------------------------
// co2fc_pkg
// Shared types, constants and helper functions for the co2 frame checker:
// frame layout, crc-8 step, status codes and float to ppm conversion.
// ----------------------------------------------------------------------------
package co2fc_pkg;

  localparam int unsigned FRAME_BYTES = 18;
  localparam int unsigned RING_DEPTH  = 5;
  localparam int unsigned HALF_WORDS  = 6;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // byte position of the last frame byte
  localparam logic [4:0] LAST_POS = 5'(FRAME_BYTES - 1);

  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_CRC  = 2'd1;
  localparam status_t ST_NAN  = 2'd2;
  localparam status_t ST_ZERO = 2'd3;

  // role of a byte inside its three-byte group
  typedef logic [1:0] phase_t;
  localparam phase_t PH_HIGH = 2'd0;
  localparam phase_t PH_LOW  = 2'd1;
  localparam phase_t PH_CRC  = 2'd2;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic phase_t byte_phase(input logic [4:0] pos);
    phase_t ph;
    case (pos) inside
      5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15:  ph = PH_HIGH;
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16: ph = PH_LOW;
      default:                               ph = PH_CRC;
    endcase
    return ph;
  endfunction

  function automatic logic [2:0] byte_word(input logic [4:0] pos);
    logic [2:0] w;
    case (pos) inside
      5'd0, 5'd1, 5'd2:    w = 3'd0;
      5'd3, 5'd4, 5'd5:    w = 3'd1;
      5'd6, 5'd7, 5'd8:    w = 3'd2;
      5'd9, 5'd10, 5'd11:  w = 3'd3;
      5'd12, 5'd13, 5'd14: w = 3'd4;
      default:             w = 3'd5;
    endcase
    return w;
  endfunction

  // ieee single to unsigned 16-bit, truncating, negatives to zero, saturating
  function automatic logic [15:0] float_to_u16(input logic [31:0] bits);
    logic [7:0]  e;
    logic [7:0]  sh;
    logic [23:0] mant;
    logic [15:0] r;
    e    = bits[30:23];
    sh   = e - 8'd127;
    mant = {1'b1, bits[22:0]};
    if (bits[31] || e < 8'd127) begin
      r = 16'd0;
    end else if (sh >= 8'd16) begin
      r = 16'hFFFF;
    end else begin
      r = 16'(mant >> (5'd23 - sh[4:0]));
    end
    return r;
  endfunction

endpackage

/* rtl/co2_frame_check_median_average.sv */
// ----------------------------------------------------------------------------
// co2_frame_check_median_average
// Checks an 18-byte co2 sensor frame (crc-8 per word, nan/inf, zero co2),
// keeps a median-of-five ring of co2 readings and a running average.
// ----------------------------------------------------------------------------
//  channel | dir | ports                             | word
//  in      | in  | in_tvalid/in_tready/in_tdata/tuser | one frame byte
//  out     | out | out_tvalid/out_tready/out_tdata/tuser | one frame result
//  cfg     | in  | cfg_psel/penable/pwrite/paddr/...  | average_shift register
//
//  one byte is taken per cycle while in_tready is high; crc and word assembly update on the fly
//  after its last byte the result of a frame is registered in order through check,
//  convert and ring write, median, and average update into the output register
//  the last byte of a frame waits while an earlier result is still in flight
//  or not yet taken, all other bytes flow on during an output stall
//  rst_n is synchronous; ring and average are first written by the first good frame
// ----------------------------------------------------------------------------
module co2_frame_check_median_average
  import co2fc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // rx_byte
  input  logic        in_tuser,     // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,    // co2_median, co2_average, temperature_bits, humidity_bits
  output logic [1:0]  out_tuser,    // status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration
  logic [3:0] shift_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {28'd0, shift_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 4'd5;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      shift_r <= cfg_pwdata[3:0];
    end
  end

  // byte assembly state
  logic [4:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  hi_r, hi_nxt;
  status_t     err_r, err_nxt;
  logic [15:0] hw_r [HALF_WORDS];
  logic [15:0] hw_nxt [HALF_WORDS];

  // result pipeline
  logic        s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  status_t     s1_status_r, s2_status_r, s3_status_r;
  logic [31:0] s1_co2_r;
  logic [31:0] s1_temp_r, s1_hum_r, s2_temp_r, s2_hum_r, s3_temp_r, s3_hum_r;
  logic [15:0] s3_med_r;
  logic [95:0] out_data_r;
  status_t     out_status_r;

  logic        take, frame_end, busy;
  logic [4:0]  pos_eff;
  logic [7:0]  crc_eff;
  status_t     err_eff, err_chk;
  phase_t      ph;
  logic [2:0]  wd;

  assign busy      = s1_valid_r || s2_valid_r || s3_valid_r || out_valid_r;
  assign in_tready = !(pos_r == LAST_POS && busy);
  assign take      = in_tvalid && in_tready;

  assign pos_eff = in_tuser ? 5'd0 : pos_r;
  assign crc_eff = in_tuser ? CRC_INIT : crc_r;
  assign err_eff = in_tuser ? ST_OK : err_r;
  assign ph      = byte_phase(pos_eff);
  assign wd      = byte_word(pos_eff);

  always_comb begin
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    hi_nxt    = hi_r;
    err_nxt   = err_r;
    hw_nxt    = hw_r;
    frame_end = 1'b0;
    err_chk   = err_eff;
    if (take) begin
      pos_nxt = pos_eff;
      crc_nxt = crc_eff;
      err_nxt = err_eff;
      if (pos_eff < 5'(FRAME_BYTES)) begin
        pos_nxt = pos_eff + 5'd1;
        case (ph)
          PH_HIGH: begin
            hi_nxt  = in_tdata;
            crc_nxt = crc8_update(crc_eff, in_tdata);
          end
          PH_LOW: begin
            crc_nxt    = crc8_update(crc_eff, in_tdata);
            hw_nxt[wd] = {hi_r, in_tdata};
          end
          default: begin
            if (err_chk == ST_OK && crc_eff != in_tdata) err_chk = ST_CRC;
            crc_nxt = CRC_INIT;
            // second word of a value: exponent sits in the high half
            if (wd[0] && err_chk == ST_OK && hw_r[{wd[2:1], 1'b0}][14:7] == 8'hFF) begin
              err_chk = ST_NAN;
            end
            if (pos_eff == LAST_POS) begin
              if (err_chk == ST_OK && hw_r[0][14:0] == 15'd0 && hw_r[1] == 16'd0) begin
                err_chk = ST_ZERO;
              end
              frame_end = 1'b1;
            end
            err_nxt = err_chk;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 5'd0;
      crc_r <= CRC_INIT;
      hi_r  <= 8'd0;
      err_r <= ST_OK;
      for (int i = 0; i < HALF_WORDS; i++) hw_r[i] <= 16'd0;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      hi_r  <= hi_nxt;
      err_r <= err_nxt;
      hw_r  <= hw_nxt;
    end
  end

  // stage 1: frame verdict and value words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= frame_end;
    end
    if (frame_end) begin
      s1_status_r <= err_chk;
      s1_co2_r    <= {hw_r[0], hw_r[1]};
      s1_temp_r   <= {hw_r[2], hw_r[3]};
      s1_hum_r    <= {hw_r[4], hw_r[5]};
    end
  end

  // stage 2: conversion and ring write
  logic [15:0] ring_r [RING_DEPTH];
  logic [15:0] avg_r;
  logic [2:0]  slot_r;
  logic        filled_r;
  logic [15:0] co2_ppm;
  logic [2:0]  slot_eff;
  logic        s1_ok;

  assign co2_ppm  = float_to_u16(s1_co2_r);
  assign slot_eff = (slot_r >= 3'(RING_DEPTH)) ? 3'd0 : slot_r;
  assign s1_ok    = s1_valid_r && s1_status_r == ST_OK;

  // running average, updated from the median stage
  logic               s3_ok;
  logic signed [16:0] delta, bias, change;
  logic [15:0]        avg_new;

  assign s3_ok  = s3_valid_r && s3_status_r == ST_OK;
  assign delta  = $signed({1'b0, s3_med_r}) - $signed({1'b0, avg_r});
  // bias negative steps so the shift truncates toward zero
  assign bias   = delta[16] ? $signed((17'd1 << shift_r) - 17'd1) : 17'sd0;
  assign change = (delta + bias) >>> shift_r;
  assign avg_new = avg_r + change[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= 3'd0;
      filled_r <= 1'b0;
    end else if (s1_ok) begin
      if (!filled_r) begin
        slot_r   <= 3'd1;
        filled_r <= 1'b1;
      end else begin
        slot_r <= (slot_eff == 3'(RING_DEPTH - 1)) ? 3'd0 : slot_eff + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ok) begin
      if (!filled_r) begin
        for (int i = 0; i < RING_DEPTH; i++) ring_r[i] <= co2_ppm;
      end else begin
        ring_r[slot_eff] <= co2_ppm;
      end
    end
    if (s1_ok && !filled_r) begin
      avg_r <= co2_ppm;
    end else if (s3_ok) begin
      avg_r <= avg_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_status_r <= s1_status_r;
    s2_temp_r   <= s1_temp_r;
    s2_hum_r    <= s1_hum_r;
  end

  // stage 3: median by rank, ties broken by ring index
  logic [2:0]  rank [RING_DEPTH];
  logic [15:0] med;

  always_comb begin
    med = ring_r[0];
    for (int i = 0; i < RING_DEPTH; i++) begin
      rank[i] = 3'd0;
      for (int j = 0; j < RING_DEPTH; j++) begin
        if (j != i && (ring_r[j] < ring_r[i] || (ring_r[j] == ring_r[i] && j < i))) begin
          rank[i] = rank[i] + 3'd1;
        end
      end
    end
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (rank[i] == 3'd2) med = ring_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_status_r <= s2_status_r;
    s3_med_r    <= med;
    s3_temp_r   <= s2_temp_r;
    s3_hum_r    <= s2_hum_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_valid_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (s3_valid_r) begin
      out_status_r <= s3_status_r;
      out_data_r   <= s3_ok ? {s3_hum_r, s3_temp_r, avg_new, s3_med_r} : 96'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // a result never reaches the output register while an older one waits
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> !out_valid_r)
    else $error("result overwrote a pending output word");

  // the last byte of a frame waits while a result is busy, so at most one result is in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r}))
    else $error("more than one frame result in flight");

  // write slot stays inside the ring once it is filled
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r |-> (slot_r < 3'(RING_DEPTH)))
    else $error("ring write slot out of range");

  // ring fills on the first good frame only
  a_fill_once: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(filled_r) |-> ($past(s1_ok) && slot_r == 3'd1))
    else $error("ring filled without a good frame");

endmodule

/* tb/co2fc_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// co2fc_tb_pkg
// Register addresses and the crc-8 step shared by the frame generator in the
// testbench top and the result predictor in the checker.
// ----------------------------------------------------------------------------
package co2fc_tb_pkg;
  import co2fc_pkg::*;

  localparam logic [2:0] SHIFT_ADDR  = 3'd0;
  // no register lives here, writes must leave the shift alone
  localparam logic [2:0] UNUSED_ADDR = 3'd4;
  localparam logic [3:0] SHIFT_RESET = 4'd5;

  // msb-first crc-8, one data bit per iteration
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

endpackage

/* tb/co2_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// co2_frame_checker
// Watches the byte, result and register channels, predicts each frame result
// (crc, nan/inf and zero checks, ppm ring median and running average) and
// compares every result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module co2_frame_checker
  import co2fc_pkg::*;
  import co2fc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,     // rx_byte
  input  logic        in_tuser,     // frame_start
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,    // co2_median, co2_average, temperature_bits, humidity_bits
  input  logic [1:0]  out_tuser,    // status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          results_pending
);

  typedef struct packed {
    status_t     status;
    logic [15:0] median;
    logic [15:0] average;
    logic [31:0] temp;
    logic [31:0] hum;
  } frame_result_t;

  frame_result_t results_due[$];

  int          byte_pos;
  logic [7:0]  crc_run;
  logic [7:0]  high_byte;
  logic [31:0] reading_bits[3];
  status_t     frame_status;
  logic [15:0] ring[RING_DEPTH];
  int          ring_slot;
  logic        ring_full;
  logic [15:0] ema;
  logic [3:0]  ema_shift;

  initial begin
    fail_count      = 0;
    results_pending = 0;
  end

  function automatic logic [15:0] ppm_from_float(input logic [31:0] f);
    int          e;
    logic [23:0] m;
    e = int'(f[30:23]) - 127;
    m = {1'b1, f[22:0]};
    if (f[31] || e < 0) return 16'd0;
    if (e >= 16) return 16'hFFFF;
    return 16'(m >> (23 - e));
  endfunction

  function automatic logic [15:0] ring_median();
    logic [15:0] v[RING_DEPTH];
    logic [15:0] t;
    for (int i = 0; i < RING_DEPTH; i++) v[i] = ring[i];
    for (int i = 0; i < RING_DEPTH - 1; i++) begin
      for (int j = 0; j < RING_DEPTH - 1 - i; j++) begin
        if (v[j] > v[j + 1]) begin
          t        = v[j];
          v[j]     = v[j + 1];
          v[j + 1] = t;
        end
      end
    end
    return v[RING_DEPTH / 2];
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic mark);
    int            p;
    int            word;
    int            v;
    int            diff;
    int            step;
    logic [15:0]   ppm;
    frame_result_t r;
    if (mark) begin
      byte_pos     = 0;
      crc_run      = CRC_INIT;
      frame_status = ST_OK;
    end
    // trailing bytes after a complete frame are dropped
    if (byte_pos >= FRAME_BYTES) return;
    p        = byte_pos;
    byte_pos = byte_pos + 1;
    word     = p / 3;
    v        = word / 2;
    case (p % 3)
      0: begin
        high_byte = b;
        crc_run   = crc8_step(crc_run, b);
      end
      1: begin
        crc_run = crc8_step(crc_run, b);
        if (word % 2 == 0) reading_bits[v][31:16] = {high_byte, b};
        else reading_bits[v][15:0] = {high_byte, b};
      end
      default: begin
        if (frame_status == ST_OK && crc_run != b) frame_status = ST_CRC;
        crc_run = CRC_INIT;
        if (word % 2 == 1 && frame_status == ST_OK && reading_bits[v][30:23] == 8'hFF)
          frame_status = ST_NAN;
        if (p == FRAME_BYTES - 1) begin
          if (frame_status == ST_OK && reading_bits[0][30:0] == 31'd0) frame_status = ST_ZERO;
          r        = '0;
          r.status = frame_status;
          if (frame_status == ST_OK) begin
            ppm = ppm_from_float(reading_bits[0]);
            if (!ring_full) begin
              // first good reading seeds the whole ring and the average
              for (int i = 0; i < RING_DEPTH; i++) ring[i] = ppm;
              ema       = ppm;
              ring_slot = 1;
              ring_full = 1'b1;
            end else begin
              ring[ring_slot] = ppm;
              ring_slot = (ring_slot >= RING_DEPTH - 1) ? 0 : ring_slot + 1;
            end
            r.median = ring_median();
            diff     = int'(r.median) - int'(ema);
            step     = diff / (1 << ema_shift);
            ema      = 16'(int'(ema) + step);
            r.average = ema;
            r.temp    = reading_bits[1];
            r.hum     = reading_bits[2];
          end
          results_due.push_back(r);
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      byte_pos     = 0;
      crc_run      = CRC_INIT;
      high_byte    = 8'd0;
      frame_status = ST_OK;
      ring_slot    = 0;
      ring_full    = 1'b0;
      ema          = 16'd0;
      ema_shift    = SHIFT_RESET;
      for (int i = 0; i < 3; i++) reading_bits[i] = 32'd0;
      for (int i = 0; i < RING_DEPTH; i++) ring[i] = 16'd0;
      results_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == SHIFT_ADDR)
        ema_shift = cfg_pwdata[3:0];
      if (in_tvalid && in_tready) absorb_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          $error("result word with no frame pending, status %0d", out_tuser);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("status", 32'(want.status), 32'(out_tuser));
          check_field("co2_median", 32'(want.median), 32'(out_tdata[15:0]));
          check_field("co2_average", 32'(want.average), 32'(out_tdata[31:16]));
          check_field("temperature_bits", want.temp, out_tdata[63:32]);
          check_field("humidity_bits", want.hum, out_tdata[95:64]);
        end
      end
    end
    results_pending = results_due.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sensor frames into the co2 frame checker: a directed set of edge
// cases, then random frames, broken frames and noise under several average
// shift settings, with random gaps on the byte side and stalls on the result
// side. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import co2fc_pkg::*;
  import co2fc_tb_pkg::*;

  localparam int ITEMS       = 650;
  localparam int MIN_FRAMES  = 30;
  localparam int PHASES      = 6;
  localparam int SETTLE      = 12;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;     // rx_byte
  logic        in_tuser = 1'b0;     // frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;           // co2_median, co2_average, temperature_bits, humidity_bits
  logic [1:0]  out_tuser;           // status
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int results_pending;
  int cycle_count = 0;
  int items_sent = 0;
  int frames_sent = 0;
  bit steady = 1'b0;

  always #10 clk = ~clk;

  co2_frame_check_median_average dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  co2_frame_checker mon (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .results_pending(results_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: runs of ready with short or long stalls, sometimes long clean runs
  initial begin
    int run;
    int stall;
    forever begin
      run   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      out_tready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic mark, input bit counted);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= mark;
    do @(posedge clk); while (!in_tready);
    if (counted) items_sent++;
  endtask

  // bad_word selects one half word whose crc byte gets corrupted, -1 for none
  task automatic send_frame(input logic [31:0] co2, input logic [31:0] temp,
                            input logic [31:0] hum, input int bad_word,
                            input logic first_mark, input int cut);
    logic [31:0] vals[3];
    logic [7:0]  bytes[FRAME_BYTES];
    logic [15:0] w;
    logic [7:0]  c;
    vals = '{co2, temp, hum};
    for (int k = 0; k < HALF_WORDS; k++) begin
      w = (k % 2 == 0) ? vals[k / 2][31:16] : vals[k / 2][15:0];
      c = crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
      if (k == bad_word) c = c ^ 8'($urandom_range(1, 255));
      bytes[3 * k]     = w[15:8];
      bytes[3 * k + 1] = w[7:0];
      bytes[3 * k + 2] = c;
    end
    for (int i = 0; i < cut; i++) send_byte(bytes[i], (i == 0) ? first_mark : 1'b0, 1'b1);
    if (cut == FRAME_BYTES) frames_sent++;
  endtask

  // unmarked bytes after a full frame, dropped by the block
  task automatic send_trailer(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0, 1'b0);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_co2_bits();
    int r;
    r = $urandom_range(0, 99);
    // mostly plausible ppm readings, between 256 and 8191
    if (r < 70) return {1'b0, 8'($urandom_range(135, 139)), 23'($urandom)};
    if (r < 80) return {1'($urandom), 8'($urandom_range(110, 150)), 23'($urandom)};
    if (r < 84) return {1'($urandom), 31'd0};
    if (r < 88) return {1'($urandom), 8'hFF, 23'($urandom)};
    return 32'($urandom);
  endfunction

  function automatic logic [31:0] rand_env_bits();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return {1'($urandom), 8'($urandom_range(120, 134)), 23'($urandom)};
    if (r < 88) return {1'($urandom), 8'hFF, 23'($urandom_range(0, 1) ? $urandom : 0)};
    return 32'($urandom);
  endfunction

  task automatic random_burst();
    int r;
    int n;
    steady = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 85) begin
      send_frame(rand_co2_bits(), rand_env_bits(), rand_env_bits(),
                 ($urandom_range(0, 99) < 8) ? $urandom_range(0, HALF_WORDS - 1) : -1,
                 1'b1, FRAME_BYTES);
      if ($urandom_range(0, 9) == 0) send_trailer($urandom_range(1, 4));
    end else if (r < 93) begin
      // frame cut short, the next mark restarts it
      send_frame(rand_co2_bits(), rand_env_bits(), rand_env_bits(), -1, 1'b1,
                 $urandom_range(1, FRAME_BYTES - 1));
    end else begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom), ($urandom_range(0, 7) == 0), 1'b1);
    end
  endtask

  initial begin
    logic [3:0] shifts[PHASES];
    shifts = '{4'd0, 4'd15, 4'd3, 4'd1, 4'($urandom_range(0, 15)), 4'd9};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first byte after reset carries no mark and still opens a frame
    send_frame(32'h43C80000, 32'h41C80000, 32'h42480000, -1, 1'b0, FRAME_BYTES);
    send_frame(32'h477FFFFF, 32'h00000000, 32'hFFFFFFFE, -1, 1'b1, FRAME_BYTES);
    send_frame(32'h7F7FFFFF, 32'h80000000, 32'h7F7FFFFF, -1, 1'b1, FRAME_BYTES);
    send_frame(32'hC3C80000, 32'h41C80000, 32'h42480000, -1, 1'b1, FRAME_BYTES);
    send_frame(32'h3F000000, 32'h41C80000, 32'h42480000, -1, 1'b1, FRAME_BYTES);
    send_frame(32'h00000000, 32'h41C80000, 32'h42480000, -1, 1'b1, FRAME_BYTES);
    send_frame(32'h80000000, 32'h41C80000, 32'h42480000, -1, 1'b1, FRAME_BYTES);
    // crc error ahead of a nan keeps the crc status
    send_frame(32'h43C80000, 32'h7FC00000, 32'h42480000, 0, 1'b1, FRAME_BYTES);
    // infinity ahead of a crc error keeps the nan status
    send_frame(32'h43C80000, 32'h7F800000, 32'h42480000, 5, 1'b1, FRAME_BYTES);
    send_frame(32'h43C80000, 32'h41C80000, 32'hFFC00000, -1, 1'b1, FRAME_BYTES);
    // crc and nan on the same value: crc is judged first
    send_frame(32'h7FC00001, 32'h41C80000, 32'h42480000, 1, 1'b1, FRAME_BYTES);
    send_frame(32'hFF800000, 32'h41C80000, 32'h42480000, -1, 1'b1, FRAME_BYTES);
    send_frame(32'h44FA0000, 32'h41200000, 32'h42C80000, -1, 1'b1, FRAME_BYTES);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b0);
    send_frame(32'h447A0000, 32'h41C80000, 32'h42480000, -1, 1'b1, 7);
    send_frame(32'h447A0000, 32'h41C80000, 32'h42480000, -1, 1'b1, FRAME_BYTES);
    send_frame(32'h45000000, 32'hC1200000, 32'h00000001, -1, 1'b1, FRAME_BYTES);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == 2) write_reg(SHIFT_ADDR, 32'hFFFF_FFF0 | 32'(shifts[ph]));
      else write_reg(SHIFT_ADDR, 32'(shifts[ph]));
      if (ph == 3) write_reg(UNUSED_ADDR, 32'h0000_000C);
      // every shift setting sees at least one burst
      do random_burst();
      while (items_sent < ITEMS * (ph + 1) / PHASES ||
             frames_sent < MIN_FRAMES * (ph + 1) / PHASES);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
